### rtl/rscp_pkg.sv
// Shared types, constants and saturating fixed-point helpers for the ray/segment unit.
`timescale 1ns / 1ps
package rscp_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// derived widths
	localparam int OFF_W  = COORD_WIDTH + 1;        // differences of two coordinates
	localparam int SQ_W   = 2 * COORD_WIDTH + 2;    // squared segment length
	localparam int LEN_W  = COORD_WIDTH + 1;        // segment length
	localparam int EXT_W  = LEN_W - 1;              // half length
	localparam int U_W    = FRAC_BITS + 2;          // unit direction component
	localparam int RP_W   = COORD_WIDTH - 1;        // ray parameter field

	// unit latencies
	localparam int QMUL_LAT  = 4;
	localparam int SQRT_LAT  = LEN_W;
	localparam int DIV_STEPS = 64 + FRAC_BITS;
	localparam int DIV_LAT   = DIV_STEPS + 2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [63:0] fx_t;

	localparam fx_t LIM  = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam fx_t ONE  = 64'sd1 <<< FRAC_BITS;
	localparam fx_t CMAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
	localparam fx_t CMIN = -CMAX - 64'sd1;

	typedef struct packed {
		coord_t ray_origin_x;
		coord_t ray_origin_y;
		coord_t ray_origin_z;
		coord_t ray_dir_x;
		coord_t ray_dir_y;
		coord_t ray_dir_z;
		coord_t seg_start_x;
		coord_t seg_start_y;
		coord_t seg_start_z;
		coord_t seg_end_x;
		coord_t seg_end_y;
		coord_t seg_end_z;
	} query_t;

	typedef struct packed {
		coord_t ray_point_x;
		coord_t ray_point_y;
		coord_t ray_point_z;
		coord_t seg_point_x;
		coord_t seg_point_y;
		coord_t seg_point_z;
		logic [RP_W-1:0] ray_param;
		coord_t seg_param;
	} result_t;

	// add with saturation to +-LIM
	function automatic fx_t sadd(fx_t a, fx_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(LIM))
			return LIM;
		else if (s < -65'(LIM))
			return -LIM;
		return fx_t'(s[63:0]);
	endfunction

	function automatic logic [63:0] fmag(fx_t x);
		return x[63] ? 64'(-x) : 64'(x);
	endfunction

	function automatic fx_t mx0(fx_t x);
		return (x < 0) ? fx_t'(0) : x;
	endfunction

	function automatic fx_t fclamp(fx_t x, fx_t lo, fx_t hi);
		if (x < lo)
			return lo;
		else if (x > hi)
			return hi;
		return x;
	endfunction

	// clamp into a coordinate field
	function automatic coord_t to_coord(fx_t x);
		if (x > CMAX)
			return coord_t'(CMAX);
		else if (x < CMIN)
			return coord_t'(CMIN);
		return x[COORD_WIDTH-1:0];
	endfunction

endpackage

### rtl/rscp_qmul.sv
// Pipelined fixed-point multiply: magnitude product, shift by the fraction, saturate, sign.
`timescale 1ns / 1ps
module rscp_qmul (
	input  logic           clk,
	input  rscp_pkg::fx_t  a,
	input  rscp_pkg::fx_t  b,
	output rscp_pkg::fx_t  p
);
	import rscp_pkg::*;

	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  am_s1, bm_s1;
	logic [63:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	logic [127:0] prod_s3;
	logic [127:0] sh;
	fx_t          r;

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		neg_s1 <= a[63] ^ b[63];
		am_s1  <= fmag(a);
		bm_s1  <= fmag(b);
	end

	// four 32x32 partial products
	always_ff @(posedge clk) begin
		neg_s2 <= neg_s1;
		p00_s2 <= am_s1[31:0]  * bm_s1[31:0];
		p01_s2 <= am_s1[31:0]  * bm_s1[63:32];
		p10_s2 <= am_s1[63:32] * bm_s1[31:0];
		p11_s2 <= am_s1[63:32] * bm_s1[63:32];
	end

	// merge partials
	always_ff @(posedge clk) begin
		neg_s3  <= neg_s2;
		prod_s3 <= 128'(p00_s2) + (128'(p01_s2) << 32) + (128'(p10_s2) << 32)
			+ (128'(p11_s2) << 64);
	end

	// truncate toward zero, saturate, apply sign
	always_comb begin
		sh = prod_s3 >> FRAC_BITS;
		if (|sh[127:62])
			r = LIM;
		else
			r = fx_t'({2'b00, sh[61:0]});
	end

	always_ff @(posedge clk) begin
		p <= neg_s3 ? -r : r;
	end

endmodule

### rtl/rscp_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rscp_isqrt (
	input  logic                       clk,
	input  logic [rscp_pkg::SQ_W-1:0]  n,
	output logic [rscp_pkg::LEN_W-1:0] root
);
	import rscp_pkg::*;

	localparam int STEPS = LEN_W;
	localparam int REM_W = LEN_W + 3;

	logic [SQ_W-1:0]  n_s    [STEPS];
	logic [REM_W-1:0] rem_s  [STEPS];
	logic [LEN_W-1:0] root_s [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [SQ_W-1:0]  n_in;
		logic [REM_W-1:0] rem_in;
		logic [LEN_W-1:0] root_in;
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] trial;

		if (k == 0) begin : g_first
			assign n_in    = n;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign n_in    = n_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		// bring down two bits, try root*4+1
		assign t     = {rem_in[REM_W-3:0], n_in[SQ_W-1 -: 2]};
		assign trial = REM_W'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			n_s[k] <= n_in << 2;
			if (t >= trial) begin
				rem_s[k]  <= t - trial;
				root_s[k] <= {root_in[LEN_W-2:0], 1'b1};
			end else begin
				rem_s[k]  <= t;
				root_s[k] <= {root_in[LEN_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_s[STEPS-1];

endmodule

### rtl/rscp_qdiv.sv
// Pipelined fixed-point divide a*2^FRAC/b, restoring, one quotient bit per stage, saturated.
`timescale 1ns / 1ps
module rscp_qdiv (
	input  logic           clk,
	input  rscp_pkg::fx_t  a,
	input  rscp_pkg::fx_t  b,
	output rscp_pkg::fx_t  quo
);
	import rscp_pkg::*;

	localparam int NW = DIV_STEPS;

	logic          neg_s [DIV_STEPS+1];
	logic [NW-1:0] num_s [DIV_STEPS+1];
	logic [NW-1:0] q_s   [DIV_STEPS+1];
	logic [63:0]   ub_s  [DIV_STEPS+1];
	logic [63:0]   rem_s [DIV_STEPS+1];
	fx_t           r;

	// operand magnitudes, dividend scaled by the fraction
	always_ff @(posedge clk) begin
		neg_s[0] <= a[63] ^ b[63];
		num_s[0] <= {fmag(a), {FRAC_BITS{1'b0}}};
		ub_s[0]  <= fmag(b);
		rem_s[0] <= '0;
		q_s[0]   <= '0;
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [63:0] t;
		assign t = {rem_s[k-1][62:0], num_s[k-1][NW-1]};

		always_ff @(posedge clk) begin
			neg_s[k] <= neg_s[k-1];
			ub_s[k]  <= ub_s[k-1];
			num_s[k] <= num_s[k-1] << 1;
			if (t >= ub_s[k-1]) begin
				rem_s[k] <= t - ub_s[k-1];
				q_s[k]   <= {q_s[k-1][NW-2:0], 1'b1};
			end else begin
				rem_s[k] <= t;
				q_s[k]   <= {q_s[k-1][NW-2:0], 1'b0};
			end
		end
	end

	// saturate and sign
	always_comb begin
		if (|q_s[DIV_STEPS][NW-1:62])
			r = LIM;
		else
			r = fx_t'({2'b00, q_s[DIV_STEPS][61:0]});
	end

	always_ff @(posedge clk) begin
		quo <= neg_s[DIV_STEPS] ? -r : r;
	end

endmodule

### rtl/ray_segment_closest_points.sv
// Top level: pipelined closest points between a ray and a segment in 3-D fixed point.
//
//   port    | dir | beat marker    | contents
//   query   | in  | start & !busy  | ray origin, ray direction, segment endpoints
//   result  | out | done           | ray point, segment point, ray and segment parameters
//
// One query enters per cycle; busy never rises. The path from each query to its result
// runs through the length square root (LEN_W stages), two restoring dividers
// (64+FRAC_BITS stages each) and four 4-stage multiplier rounds. Reset clears only
// the valid chain; the result strobe is high for one cycle and the receiver cannot
// stall it.
`timescale 1ns / 1ps
module ray_segment_closest_points (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rscp_pkg::query_t  query,
	output logic              done,
	output rscp_pkg::result_t result
);
	import rscp_pkg::*;

	typedef logic signed [OFF_W-1:0] off_t;
	typedef logic signed [U_W-1:0]   u_t;
	typedef logic [EXT_W-1:0]        ext_t;
	typedef logic [LEN_W-1:0]        len_t;

	typedef struct packed {
		coord_t [2:0] ro;
		coord_t [2:0] rd;
		coord_t [2:0] ctr;
		off_t   [2:0] off;
		off_t   [2:0] dv;
	} geo_t;

	typedef struct packed {
		geo_t g;
		len_t len;
	} dcar_t;

	typedef struct packed {
		coord_t [2:0] ro;
		coord_t [2:0] rd;
		coord_t [2:0] ctr;
		u_t     [2:0] u;
		ext_t         ext;
	} post_t;

	typedef struct packed {
		post_t p;
		fx_t   m;
		fx_t   pr;
		fx_t   ps;
	} acar_t;

	typedef struct packed {
		post_t p;
		fx_t   dd;
		fx_t   s0c;
		fx_t   s1c;
		fx_t   sp;
		fx_t   sn;
		fx_t   cl;
		logic  mpos;
	} hcar_t;

	typedef struct packed {
		post_t p;
		logic  use_div;
		fx_t   s0x;
		fx_t   s1x;
	} icar_t;

	typedef struct packed {
		coord_t [2:0] ro;
		coord_t [2:0] ctr;
		fx_t          s0;
		fx_t          s1;
	} jcar_t;

	localparam int P5    = 4 + SQRT_LAT;
	localparam int P6    = P5 + DIV_LAT;
	localparam int P7    = P6 + 1 + QMUL_LAT;
	localparam int P8    = P7 + 2 + QMUL_LAT;
	localparam int P9    = P8 + 1 + QMUL_LAT;
	localparam int P10   = P9 + 1 + DIV_LAT;
	localparam int P11   = P10 + 1 + QMUL_LAT;
	localparam int TOTAL = P11 + 2;

	// valid chain, one bit per pipeline position
	logic [TOTAL-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[TOTAL-2:0], start & ~busy};
	end

	assign busy = 1'b0;
	assign done = vld_q[TOTAL-1];

	// input register
	query_t in_s1;

	always_ff @(posedge clk) begin
		in_s1 <= query;
	end

	coord_t ro_c [3], rd_c [3], pa_c [3], pb_c [3];

	assign ro_c[0] = in_s1.ray_origin_x;
	assign ro_c[1] = in_s1.ray_origin_y;
	assign ro_c[2] = in_s1.ray_origin_z;
	assign rd_c[0] = in_s1.ray_dir_x;
	assign rd_c[1] = in_s1.ray_dir_y;
	assign rd_c[2] = in_s1.ray_dir_z;
	assign pa_c[0] = in_s1.seg_start_x;
	assign pa_c[1] = in_s1.seg_start_y;
	assign pa_c[2] = in_s1.seg_start_z;
	assign pb_c[0] = in_s1.seg_end_x;
	assign pb_c[1] = in_s1.seg_end_y;
	assign pb_c[2] = in_s1.seg_end_z;

	// center, offset from center, segment vector and its magnitude
	geo_t                   a_c, a_s2;
	logic [COORD_WIDTH-1:0] dvm_c [3];
	logic [COORD_WIDTH-1:0] dvm_s2 [3];

	always_comb begin
		logic signed [COORD_WIDTH:0] csum;
		for (int i = 0; i < 3; i++) begin
			csum        = OFF_W'(pa_c[i]) + OFF_W'(pb_c[i]);
			a_c.ro[i]   = ro_c[i];
			a_c.rd[i]   = rd_c[i];
			a_c.ctr[i]  = csum[COORD_WIDTH:1];
			a_c.off[i]  = OFF_W'(ro_c[i]) - OFF_W'(a_c.ctr[i]);
			a_c.dv[i]   = OFF_W'(pb_c[i]) - OFF_W'(pa_c[i]);
			dvm_c[i]    = a_c.dv[i][COORD_WIDTH] ? COORD_WIDTH'(-a_c.dv[i])
				: a_c.dv[i][COORD_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		a_s2 <= a_c;
		for (int i = 0; i < 3; i++)
			dvm_s2[i] <= dvm_c[i];
	end

	// squares, then squared length
	geo_t                     b_s3, c_s4;
	logic [2*COORD_WIDTH-1:0] sqv_s3 [3];
	logic [SQ_W-1:0]          sq_s4;

	always_ff @(posedge clk) begin
		b_s3 <= a_s2;
		for (int i = 0; i < 3; i++)
			sqv_s3[i] <= dvm_s2[i] * dvm_s2[i];
		c_s4  <= b_s3;
		sq_s4 <= SQ_W'(sqv_s3[0]) + SQ_W'(sqv_s3[1]) + SQ_W'(sqv_s3[2]);
	end

	// segment length
	len_t len_w;

	rscp_isqrt u_sqrt (
		.clk  (clk),
		.n    (sq_s4),
		.root (len_w)
	);

	geo_t sqd_q [SQRT_LAT];

	always_ff @(posedge clk) begin
		sqd_q[0] <= c_s4;
		for (int k = 1; k < SQRT_LAT; k++)
			sqd_q[k] <= sqd_q[k-1];
	end

	// unit direction: d / len per component
	fx_t   uq_w [3];
	dcar_t dvd_q [DIV_LAT];

	for (genvar i = 0; i < 3; i++) begin : g_udiv
		rscp_qdiv u_div (
			.clk (clk),
			.a   (fx_t'(sqd_q[SQRT_LAT-1].dv[i])),
			.b   (fx_t'(len_w)),
			.quo (uq_w[i])
		);
	end

	always_ff @(posedge clk) begin
		dvd_q[0] <= '{g: sqd_q[SQRT_LAT-1], len: len_w};
		for (int k = 1; k < DIV_LAT; k++)
			dvd_q[k] <= dvd_q[k-1];
	end

	// zero-length segment gives zero direction
	post_t e_s5;
	off_t  off_s5 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e_s5.ro[i]  <= dvd_q[DIV_LAT-1].g.ro[i];
			e_s5.rd[i]  <= dvd_q[DIV_LAT-1].g.rd[i];
			e_s5.ctr[i] <= dvd_q[DIV_LAT-1].g.ctr[i];
			e_s5.u[i]   <= (dvd_q[DIV_LAT-1].len != '0) ? uq_w[i][U_W-1:0] : '0;
			off_s5[i]   <= dvd_q[DIV_LAT-1].g.off[i];
		end
		e_s5.ext <= dvd_q[DIV_LAT-1].len[LEN_W-1:1];
	end

	// dot product terms
	fx_t p_rdu [3], p_ofr [3], p_ofu [3];

	for (genvar i = 0; i < 3; i++) begin : g_dot
		rscp_qmul u_rdu (
			.clk (clk), .a(fx_t'(e_s5.rd[i])), .b(fx_t'(e_s5.u[i])), .p(p_rdu[i]));
		rscp_qmul u_ofr (
			.clk (clk), .a(fx_t'(off_s5[i])), .b(fx_t'(e_s5.rd[i])), .p(p_ofr[i]));
		rscp_qmul u_ofu (
			.clk (clk), .a(fx_t'(off_s5[i])), .b(fx_t'(e_s5.u[i])), .p(p_ofu[i]));
	end

	post_t pd1_q [QMUL_LAT];

	always_ff @(posedge clk) begin
		pd1_q[0] <= e_s5;
		for (int k = 1; k < QMUL_LAT; k++)
			pd1_q[k] <= pd1_q[k-1];
	end

	// dot sums in two steps
	post_t f_s6, g_s7;
	fx_t   tm_s6, tr_s6, tu_s6, rdu2_s6, ofr2_s6, ofu2_s6;
	fx_t   m_s7, pr_s7, ps_s7;

	always_ff @(posedge clk) begin
		f_s6    <= pd1_q[QMUL_LAT-1];
		tm_s6   <= sadd(p_rdu[0], p_rdu[1]);
		tr_s6   <= sadd(p_ofr[0], p_ofr[1]);
		tu_s6   <= sadd(p_ofu[0], p_ofu[1]);
		rdu2_s6 <= p_rdu[2];
		ofr2_s6 <= p_ofr[2];
		ofu2_s6 <= p_ofu[2];
		g_s7    <= f_s6;
		m_s7    <= -sadd(tm_s6, rdu2_s6);
		pr_s7   <= sadd(tr_s6, ofr2_s6);
		ps_s7   <= -sadd(tu_s6, ofu2_s6);
	end

	// products of m
	fx_t mm_w, mps_w, mpr_w, me_w;

	rscp_qmul u_mm  (.clk(clk), .a(m_s7), .b(m_s7),  .p(mm_w));
	rscp_qmul u_mps (.clk(clk), .a(m_s7), .b(ps_s7), .p(mps_w));
	rscp_qmul u_mpr (.clk(clk), .a(m_s7), .b(pr_s7), .p(mpr_w));
	rscp_qmul u_me  (.clk(clk), .a(m_s7), .b(fx_t'(g_s7.ext)), .p(me_w));

	acar_t ad_q [QMUL_LAT];

	always_ff @(posedge clk) begin
		ad_q[0] <= '{p: g_s7, m: m_s7, pr: pr_s7, ps: ps_s7};
		for (int k = 1; k < QMUL_LAT; k++)
			ad_q[k] <= ad_q[k-1];
	end

	// determinant, unclamped parameters and edge candidates
	hcar_t h_c, h_s8;

	always_comb begin
		fx_t ddr;
		fx_t extf;
		acar_t ac;
		ac       = ad_q[QMUL_LAT-1];
		extf     = fx_t'(ac.p.ext);
		ddr      = sadd(ONE, -mm_w);
		h_c.p    = ac.p;
		h_c.dd   = (ddr < 0) ? -ddr : ddr;
		h_c.s0c  = sadd(mps_w, -ac.pr);
		h_c.s1c  = sadd(mpr_w, -ac.ps);
		h_c.sp   = mx0(-sadd(me_w, ac.pr));
		h_c.sn   = mx0(-sadd(-me_w, ac.pr));
		h_c.cl   = fclamp(-ac.ps, -extf, extf);
		h_c.mpos = ac.m > 0;
	end

	always_ff @(posedge clk) begin
		h_s8 <= h_c;
	end

	// half length scaled by the determinant
	fx_t dext_w;

	rscp_qmul u_dext (.clk(clk), .a(fx_t'(h_s8.p.ext)), .b(h_s8.dd), .p(dext_w));

	hcar_t hd_q [QMUL_LAT];

	always_ff @(posedge clk) begin
		hd_q[0] <= h_s8;
		for (int k = 1; k < QMUL_LAT; k++)
			hd_q[k] <= hd_q[k-1];
	end

	// region decision
	icar_t i_c, i_s9;
	fx_t   dd_s9, s0c_s9, s1c_s9;

	always_comb begin
		hcar_t hc;
		fx_t   extf;
		hc        = hd_q[QMUL_LAT-1];
		extf      = fx_t'(hc.p.ext);
		i_c.p     = hc.p;
		i_c.use_div = 1'b0;
		i_c.s0x   = '0;
		i_c.s1x   = '0;
		if (hc.dd != 0) begin
			if (hc.s0c >= 0) begin
				if (hc.s1c >= -dext_w && hc.s1c <= dext_w) begin
					i_c.use_div = 1'b1;
				end else if (hc.s1c > dext_w) begin
					i_c.s1x = extf;
					i_c.s0x = hc.sp;
				end else begin
					i_c.s1x = -extf;
					i_c.s0x = hc.sn;
				end
			end else if (hc.s1c <= -dext_w) begin
				i_c.s0x = hc.sn;
				i_c.s1x = (hc.sn > 0) ? -extf : hc.cl;
			end else if (hc.s1c <= dext_w) begin
				i_c.s0x = '0;
				i_c.s1x = hc.cl;
			end else begin
				i_c.s0x = hc.sp;
				i_c.s1x = (hc.sp > 0) ? extf : hc.cl;
			end
		end else begin
			// parallel lines
			i_c.s1x = hc.mpos ? -extf : extf;
			i_c.s0x = hc.mpos ? hc.sn : hc.sp;
		end
	end

	always_ff @(posedge clk) begin
		i_s9   <= i_c;
		dd_s9  <= hd_q[QMUL_LAT-1].dd;
		s0c_s9 <= hd_q[QMUL_LAT-1].s0c;
		s1c_s9 <= hd_q[QMUL_LAT-1].s1c;
	end

	// interior case: divide both by the determinant
	fx_t q0_w, q1_w;

	rscp_qdiv u_div0 (.clk(clk), .a(s0c_s9), .b(dd_s9), .quo(q0_w));
	rscp_qdiv u_div1 (.clk(clk), .a(s1c_s9), .b(dd_s9), .quo(q1_w));

	icar_t id_q [DIV_LAT];

	always_ff @(posedge clk) begin
		id_q[0] <= i_s9;
		for (int k = 1; k < DIV_LAT; k++)
			id_q[k] <= id_q[k-1];
	end

	post_t j_s10;
	fx_t   s0_s10, s1_s10;

	always_ff @(posedge clk) begin
		j_s10  <= id_q[DIV_LAT-1].p;
		s0_s10 <= id_q[DIV_LAT-1].use_div ? q0_w : id_q[DIV_LAT-1].s0x;
		s1_s10 <= id_q[DIV_LAT-1].use_div ? q1_w : id_q[DIV_LAT-1].s1x;
	end

	// points along ray and segment
	fx_t qrd_w [3], qus_w [3];

	for (genvar i = 0; i < 3; i++) begin : g_pt
		rscp_qmul u_rp (.clk(clk), .a(fx_t'(j_s10.rd[i])), .b(s0_s10), .p(qrd_w[i]));
		rscp_qmul u_sp (.clk(clk), .a(fx_t'(j_s10.u[i])),  .b(s1_s10), .p(qus_w[i]));
	end

	jcar_t jd_q [QMUL_LAT];

	always_ff @(posedge clk) begin
		jd_q[0] <= '{ro: j_s10.ro, ctr: j_s10.ctr, s0: s0_s10, s1: s1_s10};
		for (int k = 1; k < QMUL_LAT; k++)
			jd_q[k] <= jd_q[k-1];
	end

	fx_t rpt_s11 [3], spt_s11 [3];
	fx_t s0_s11, s1_s11;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rpt_s11[i] <= sadd(qrd_w[i], fx_t'(jd_q[QMUL_LAT-1].ro[i]));
			spt_s11[i] <= sadd(qus_w[i], fx_t'(jd_q[QMUL_LAT-1].ctr[i]));
		end
		s0_s11 <= jd_q[QMUL_LAT-1].s0;
		s1_s11 <= jd_q[QMUL_LAT-1].s1;
	end

	// output register with field saturation
	result_t out_s12;

	always_ff @(posedge clk) begin
		out_s12.ray_point_x <= to_coord(rpt_s11[0]);
		out_s12.ray_point_y <= to_coord(rpt_s11[1]);
		out_s12.ray_point_z <= to_coord(rpt_s11[2]);
		out_s12.seg_point_x <= to_coord(spt_s11[0]);
		out_s12.seg_point_y <= to_coord(spt_s11[1]);
		out_s12.seg_point_z <= to_coord(spt_s11[2]);
		out_s12.ray_param   <= (s0_s11 > CMAX) ? CMAX[RP_W-1:0] : s0_s11[RP_W-1:0];
		out_s12.seg_param   <= to_coord(s1_s11);
	end

	assign result = out_s12;

endmodule

### test/ray_segment_closest_points_test.sv
// Testbench for the ray/segment closest-point unit: directed table, then random queries.
`timescale 1ns / 1ps
module ray_segment_closest_points_test;
	import rscp_pkg::*;

	localparam int LATENCY_WAIT = 400;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int N_RANDOM     = 1200;
	localparam fx_t SAT = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam fx_t UNIT = 64'sd1 <<< FRAC_BITS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	query_t query = '0;
	result_t result;

	result_t pending_points[$];
	int errors = 0;
	int cycles = 0;

	ray_segment_closest_points dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.query(query), .done(done), .result(result)
	);

	always #2 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// fixed-point arithmetic, saturating to +-(2^62-1)
	function automatic fx_t clip(logic signed [129:0] x);
		if (x > 130'(SAT))
			return SAT;
		if (x < -130'(SAT))
			return -SAT;
		return fx_t'(x);
	endfunction

	function automatic fx_t fx_add(fx_t a, fx_t b);
		return clip(130'(a) + 130'(b));
	endfunction

	// truncated product: magnitude shifted, sign restored
	function automatic fx_t fx_mul(fx_t a, fx_t b);
		logic [127:0] p;
		logic [127:0] q;
		fx_t r;
		p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		q = p >> FRAC_BITS;
		r = (q > 128'(SAT)) ? SAT : fx_t'(q);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic fx_t fx_div(fx_t a, fx_t b);
		logic [127:0] num;
		logic [127:0] q;
		fx_t r;
		num = 128'(a < 0 ? -a : a) << FRAC_BITS;
		q = num / 128'(b < 0 ? -b : b);
		r = (q > 128'(SAT)) ? SAT : fx_t'(q);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic fx_t fx_dot(fx_t a[3], fx_t b[3]);
		return fx_add(fx_add(fx_mul(a[0], b[0]), fx_mul(a[1], b[1])), fx_mul(a[2], b[2]));
	endfunction

	function automatic fx_t fx_max0(fx_t x);
		return x < 0 ? fx_t'(0) : x;
	endfunction

	function automatic fx_t fx_clamp(fx_t x, fx_t lo, fx_t hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic coord_t sat_coord(fx_t x);
		fx_t cmax;
		cmax = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
		return coord_t'(fx_clamp(x, -cmax - 1, cmax));
	endfunction

	// floor square root of a 130-bit value
	function automatic fx_t root_floor(logic [129:0] n);
		logic [129:0] r;
		logic [129:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (130'd1 << b);
			if (c * c <= n)
				r = c;
		end
		return fx_t'(r);
	endfunction

	// closest points of ray and segment
	function automatic result_t closest_points(query_t qi);
		fx_t orig[3], dir[3], pa[3], pb[3], ctr[3], off[3], u[3], dv[3];
		fx_t len, ext, m, pr, ps, dd, s0, s1, dext, cmax;
		logic [129:0] sq;
		result_t r;
		orig = '{fx_t'(qi.ray_origin_x), fx_t'(qi.ray_origin_y), fx_t'(qi.ray_origin_z)};
		dir = '{fx_t'(qi.ray_dir_x), fx_t'(qi.ray_dir_y), fx_t'(qi.ray_dir_z)};
		pa = '{fx_t'(qi.seg_start_x), fx_t'(qi.seg_start_y), fx_t'(qi.seg_start_z)};
		pb = '{fx_t'(qi.seg_end_x), fx_t'(qi.seg_end_y), fx_t'(qi.seg_end_z)};
		cmax = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
		sq = '0;
		for (int i = 0; i < 3; i++) begin
			ctr[i] = (pa[i] + pb[i]) >>> 1;
			off[i] = clip(130'(orig[i]) - 130'(ctr[i]));
			dv[i] = pb[i] - pa[i];
			sq += 130'(dv[i] < 0 ? -dv[i] : dv[i]) * 130'(dv[i] < 0 ? -dv[i] : dv[i]);
		end
		len = root_floor(sq);
		for (int i = 0; i < 3; i++)
			u[i] = len > 0 ? fx_div(dv[i], len) : fx_t'(0);
		ext = len / 2;
		m = -fx_dot(dir, u);
		pr = fx_dot(off, dir);
		ps = -fx_dot(off, u);
		dd = fx_add(UNIT, -fx_mul(m, m));
		if (dd < 0)
			dd = -dd;
		// region analysis; det of zero means parallel lines
		if (dd > 0) begin
			s0 = fx_add(fx_mul(m, ps), -pr);
			s1 = fx_add(fx_mul(m, pr), -ps);
			dext = fx_mul(ext, dd);
			if (s0 >= 0) begin
				if (s1 >= -dext && s1 <= dext) begin
					s0 = fx_div(s0, dd);
					s1 = fx_div(s1, dd);
				end else begin
					s1 = s1 > dext ? ext : -ext;
					s0 = fx_max0(-fx_add(fx_mul(m, s1), pr));
				end
			end else if (s1 <= -dext) begin
				s0 = fx_max0(-fx_add(fx_mul(-m, ext), pr));
				s1 = s0 > 0 ? -ext : fx_clamp(-ps, -ext, ext);
			end else if (s1 <= dext) begin
				s0 = 0;
				s1 = fx_clamp(-ps, -ext, ext);
			end else begin
				s0 = fx_max0(-fx_add(fx_mul(m, ext), pr));
				s1 = s0 > 0 ? ext : fx_clamp(-ps, -ext, ext);
			end
		end else begin
			s1 = m > 0 ? -ext : ext;
			s0 = fx_max0(-fx_add(fx_mul(m, s1), pr));
		end
		r.ray_point_x = sat_coord(fx_add(fx_mul(dir[0], s0), orig[0]));
		r.ray_point_y = sat_coord(fx_add(fx_mul(dir[1], s0), orig[1]));
		r.ray_point_z = sat_coord(fx_add(fx_mul(dir[2], s0), orig[2]));
		r.seg_point_x = sat_coord(fx_add(fx_mul(u[0], s1), ctr[0]));
		r.seg_point_y = sat_coord(fx_add(fx_mul(u[1], s1), ctr[1]));
		r.seg_point_z = sat_coord(fx_add(fx_mul(u[2], s1), ctr[2]));
		r.ray_param = (RP_W)'(s0 > cmax ? cmax : s0);
		r.seg_param = sat_coord(s1);
		return r;
	endfunction

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_points.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				want = pending_points.pop_front();
				if (result.ray_point_x !== want.ray_point_x) begin
					$error("ray_point_x exp %h got %h", want.ray_point_x, result.ray_point_x);
					errors++;
				end
				if (result.ray_point_y !== want.ray_point_y) begin
					$error("ray_point_y exp %h got %h", want.ray_point_y, result.ray_point_y);
					errors++;
				end
				if (result.ray_point_z !== want.ray_point_z) begin
					$error("ray_point_z exp %h got %h", want.ray_point_z, result.ray_point_z);
					errors++;
				end
				if (result.seg_point_x !== want.seg_point_x) begin
					$error("seg_point_x exp %h got %h", want.seg_point_x, result.seg_point_x);
					errors++;
				end
				if (result.seg_point_y !== want.seg_point_y) begin
					$error("seg_point_y exp %h got %h", want.seg_point_y, result.seg_point_y);
					errors++;
				end
				if (result.seg_point_z !== want.seg_point_z) begin
					$error("seg_point_z exp %h got %h", want.seg_point_z, result.seg_point_z);
					errors++;
				end
				if (result.ray_param !== want.ray_param) begin
					$error("ray_param exp %h got %h", want.ray_param, result.ray_param);
					errors++;
				end
				if (result.seg_param !== want.seg_param) begin
					$error("seg_param exp %h got %h", want.seg_param, result.seg_param);
					errors++;
				end
			end
		end
	end

	// directed rows: query plus an optional typed-in expectation
	typedef struct {
		query_t q;
		bit has_want;
		result_t want;
	} row_t;

	function automatic query_t make_query(coord_t o[3], coord_t d[3], coord_t a[3], coord_t b[3]);
		query_t q;
		q = '{o[0], o[1], o[2], d[0], d[1], d[2], a[0], a[1], a[2], b[0], b[1], b[2]};
		return q;
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom());
			1: return coord_t'($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
			2: return coord_t'($urandom_range(0, 32'h0064_0000)) - 32'sh0032_0000;
			default: return coord_t'($urandom_range(0, 32'h0001_0000)) * ($urandom_range(0, 1) ? 1 : -1);
		endcase
	endfunction

	// mostly direction components of at most one unit in magnitude, sometimes anything
	function automatic query_t rand_query();
		coord_t o[3], d[3], a[3], b[3];
		int mode;
		mode = $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 2);
		for (int i = 0; i < 3; i++) begin
			o[i] = rand_coord(mode);
			d[i] = rand_coord(mode == 0 ? 0 : 3);
			a[i] = rand_coord(mode);
			b[i] = $urandom_range(0, 15) == 0 ? a[i] : rand_coord(mode);
		end
		if ($urandom_range(0, 5) == 0) begin
			d = '{32'sh0001_0000, 0, 0};
			if ($urandom_range(0, 1))
				d[0] = -d[0];
		end
		return make_query(o, d, a, b);
	endfunction

	task automatic send(query_t q, bit allow_gaps);
		if (allow_gaps && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		query <= q;
		pending_points.push_back(closest_points(q));
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		row_t rows[$];
		row_t r;
		coord_t zero3[3];
		coord_t ux[3];
		coord_t big[3];
		coord_t mn[3];
		int wait_cycles;
		zero3 = '{0, 0, 0};
		ux = '{32'sh0001_0000, 0, 0};
		big = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		mn = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};

		// all zero: zero-length segment, every output zero
		r.q = '0; r.has_want = 1; r.want = '0; rows.push_back(r);
		r.has_want = 0;
		// zero-length segment away from origin
		r.q = make_query(zero3, ux, '{32'sh0003_0000, 32'sh0002_0000, 0},
			'{32'sh0003_0000, 32'sh0002_0000, 0});
		rows.push_back(r);
		// parallel lines, both orientations
		r.q = make_query(zero3, ux, '{32'sh0002_0000, 32'sh0001_0000, 0},
			'{32'sh0006_0000, 32'sh0001_0000, 0});
		rows.push_back(r);
		r.q = make_query(zero3, ux, '{32'sh0006_0000, 32'sh0001_0000, 0},
			'{32'sh0002_0000, 32'sh0001_0000, 0});
		rows.push_back(r);
		// crossing segment, segment behind the ray, segment ends clamped
		r.q = make_query(zero3, ux, '{32'sh0003_0000, -32'sh0002_0000, 32'sh0001_0000},
			'{32'sh0003_0000, 32'sh0002_0000, 32'sh0001_0000});
		rows.push_back(r);
		r.q = make_query(zero3, ux, '{-32'sh0005_0000, -32'sh0002_0000, 0},
			'{-32'sh0005_0000, 32'sh0002_0000, 0});
		rows.push_back(r);
		r.q = make_query(zero3, ux, '{32'sh0003_0000, 32'sh0002_0000, 0},
			'{32'sh0003_0000, 32'sh0009_0000, 0});
		rows.push_back(r);
		r.q = make_query(zero3, ux, '{-32'sh0003_0000, 32'sh0002_0000, 0},
			'{32'sh0004_0000, 32'sh0009_0000, 0});
		rows.push_back(r);
		// direction not unit length
		r.q = make_query(zero3, '{32'sh0003_0000, 32'sh0001_0000, 0},
			'{32'sh0001_0000, 32'sh0005_0000, 0}, '{32'sh0004_0000, -32'sh0002_0000, 0});
		rows.push_back(r);
		// extremes of the fields, saturation
		r.q = make_query(big, big, mn, big); rows.push_back(r);
		r.q = make_query(mn, mn, big, mn); rows.push_back(r);
		r.q = make_query(mn, big, mn, mn); rows.push_back(r);
		r.q = make_query(big, mn, big, big); rows.push_back(r);
		r.q = make_query(zero3, big, zero3, big); rows.push_back(r);
		r.q = make_query(mn, ux, big, mn); rows.push_back(r);
		r.q = '1; rows.push_back(r);

		// reset
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (rows[i]) begin
			send(rows[i].q, 1'b0);
			if (rows[i].has_want)
				pending_points[$] = rows[i].want;
		end

		// random part, last stretch without gaps
		for (int n = 0; n < N_RANDOM; n++)
			send(rand_query(), n < N_RANDOM - 200);
		start <= 1'b0;

		wait_cycles = 0;
		while (pending_points.size() != 0 && wait_cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY_WAIT) @(posedge clk);
		if (errors == 0 && pending_points.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
